>>> design/pbds_pkg.sv
// Shared types, constants and helper functions for the packet buffer drop scheduler.
`timescale 1ns / 1ps
package pbds_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int TIME_W       = 32;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int SIZE_W       = 7;

    typedef struct packed {
        logic [TIME_W-1:0] arr_tick;
        logic [TIME_W-1:0] proc_ticks;
    } t_in_word;

    typedef struct packed {
        logic              dropped;
        logic [TIME_W-1:0] start_tick;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic capture;
        logic pop;
        logic load_out;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic pop_ok;
        logic full;
        logic out_free;
    } t_status;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] last;
        last = PTR_W'(BUFFER_DEPTH - 1);
        return (p == last) ? '0 : p + 1'b1;
    endfunction

endpackage

>>> design/pbds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pbds_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/pbds_ctrl.sv
// Controller state machine: sequences capture, pop loop, and drop or push decision.
`timescale 1ns / 1ps
module pbds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pbds_pkg::t_status i_status,
    output logic             o_in_ready,
    output pbds_pkg::t_cmd    o_cmd
);

    pbds_pkg::t_state r_state;
    pbds_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbds_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pbds_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pbds_pkg::S_POP;
                end
            end
            pbds_pkg::S_POP: begin
                if (!i_status.pop_ok) begin
                    n_state = pbds_pkg::S_DECIDE;
                end
            end
            pbds_pkg::S_DECIDE: begin
                if (i_status.out_free) begin
                    n_state = pbds_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pbds_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            pbds_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            pbds_pkg::S_POP: begin
                o_cmd.pop = i_status.pop_ok;
            end
            pbds_pkg::S_DECIDE: begin
                o_cmd.load_out = i_status.out_free;
                o_cmd.push     = i_status.out_free & ~i_status.full;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/pbds_dp.sv
// Datapath: finish-time FIFO, pointers, occupancy, start computation and output register.
`timescale 1ns / 1ps
module pbds_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pbds_pkg::t_cmd                i_cmd,
    output pbds_pkg::t_status             o_status,
    input  pbds_pkg::t_in_word            i_in_word,
    input  logic                          i_cfg_valid,
    input  logic [pbds_pkg::SIZE_W-1:0]   i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pbds_pkg::t_out_word           o_out_word
);

    pbds_pkg::t_in_word                r_in;
    pbds_pkg::t_out_word               r_out;
    logic                              r_out_valid;
    logic [pbds_pkg::PTR_W-1:0]        r_head;
    logic [pbds_pkg::PTR_W-1:0]        n_head;
    logic [pbds_pkg::PTR_W-1:0]        r_tail;
    logic [pbds_pkg::CNT_W-1:0]        r_count;
    logic [pbds_pkg::TIME_W-1:0]       r_last_finish;
    logic [pbds_pkg::SIZE_W-1:0]       r_buffer_size;
    logic [pbds_pkg::TIME_W-1:0]       rd_data;
    logic [pbds_pkg::TIME_W-1:0]       start;
    logic [pbds_pkg::TIME_W:0]         sum;
    logic [pbds_pkg::TIME_W-1:0]       finish;
    logic [pbds_pkg::CNT_W-1:0]        cap;

    assign n_head = i_cmd.pop ? pbds_pkg::next_pos(r_head) : r_head;

    pbds_ram #(
        .WIDTH (pbds_pkg::TIME_W),
        .DEPTH (pbds_pkg::BUFFER_DEPTH)
    ) u_fifo_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (r_tail),
        .i_wr_data (finish),
        .i_rd_addr (n_head),
        .o_rd_data (rd_data)
    );

    always_comb begin
        if ({{(32 - pbds_pkg::SIZE_W){1'b0}}, r_buffer_size} > 32'(pbds_pkg::BUFFER_DEPTH)) begin
            cap = pbds_pkg::CNT_W'(pbds_pkg::BUFFER_DEPTH);
        end else begin
            cap = pbds_pkg::CNT_W'(r_buffer_size);
        end
    end

    assign start  = (r_in.arr_tick > r_last_finish) ? r_in.arr_tick : r_last_finish;
    assign sum    = {1'b0, start} + {1'b0, r_in.proc_ticks};
    assign finish = sum[pbds_pkg::TIME_W] ? '1 : sum[pbds_pkg::TIME_W-1:0];

    assign o_status.pop_ok   = (r_count != '0) && (rd_data <= r_in.arr_tick);
    assign o_status.full     = (r_count >= cap);
    assign o_status.out_free = ~r_out_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_last_finish <= '0;
            r_buffer_size <= pbds_pkg::SIZE_W'(pbds_pkg::BUFFER_DEPTH);
            r_out_valid   <= 1'b0;
        end else begin
            r_head <= n_head;
            if (i_cfg_valid) begin
                r_buffer_size <= i_cfg_data;
            end
            if (i_cmd.push) begin
                r_tail        <= pbds_pkg::next_pos(r_tail);
                r_last_finish <= finish;
            end
            case ({i_cmd.push, i_cmd.pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_word;
        end
        if (i_cmd.load_out) begin
            r_out.dropped    <= ~i_cmd.push;
            r_out.start_tick <= i_cmd.push ? start : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

>>> design/packet_buffer_drop_scheduler_unit.sv
// Top level of the tail-drop packet buffer scheduler.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one packet word:
//   arrival tick and processing time. Output channel (o_out_valid / i_out_ready /
//   o_out_word) returns one word per packet: drop flag and start tick.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
//   buffer size; always ready, write it only while the block is idle.
// Timing:
//   After acceptance a packet passes through the pop loop, which pops the FIFO
//   entries that have finished, and then the decision, whose result is held in
//   the output register; the pop loop reads one FIFO entry per cycle from the
//   registered-read RAM. The next packet is taken the cycle after the result is
//   registered, not before. Every pop matches an earlier push.
// Reset:
//   Synchronous, active low. Clears pointers, occupancy and last finish tick and
//   sets the buffer size to 64. FIFO contents are not cleared.
// Back-pressure:
//   The output register holds a result until taken; a new packet is accepted
//   meanwhile, and its decision waits until the output register is free.
module packet_buffer_drop_scheduler_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  pbds_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output pbds_pkg::t_out_word         o_out_word,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pbds_pkg::SIZE_W-1:0] i_cfg_data
);

    pbds_pkg::t_cmd    cmd;
    pbds_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    pbds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    pbds_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

>>> bench/tb_packet_buffer_drop_scheduler_unit.sv
// Self-checking bench for the tail-drop packet buffer scheduler, predicted per word.
`timescale 1ns / 1ps
module tb_packet_buffer_drop_scheduler_unit;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int          OPENING_ROWS = 16;
    localparam int          SCRIPT_ROWS  = 24;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PKT,
        ROW_PKT_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [pbds_pkg::SIZE_W-1:0] size;
        logic [pbds_pkg::TIME_W-1:0] arrival;
        logic [pbds_pkg::TIME_W-1:0] proc;
        logic                        dropped;
        logic [pbds_pkg::TIME_W-1:0] start;
    } t_script_row;

    localparam logic [pbds_pkg::TIME_W-1:0] T_MAX = '1;

    t_script_row stim_script [0:SCRIPT_ROWS-1] = '{
        '{ROW_PKT_KNOWN, 7'd0,   32'd0,          32'd0,          1'b0, 32'd0},
        '{ROW_PKT_KNOWN, 7'd0,   32'd0,          32'd10,         1'b0, 32'd0},
        '{ROW_PKT_KNOWN, 7'd0,   32'd0,          32'd5,          1'b0, 32'd10},
        '{ROW_PKT_KNOWN, 7'd0,   32'd10,         32'd1,          1'b0, 32'd15},
        '{ROW_PKT_KNOWN, 7'd0,   32'd16,         32'd0,          1'b0, 32'd16},
        '{ROW_CFG,       7'd1,   32'd0,          32'd0,          1'b0, 32'd0},
        '{ROW_PKT_KNOWN, 7'd0,   32'd20,         32'd10,         1'b0, 32'd20},
        '{ROW_PKT_KNOWN, 7'd0,   32'd25,         32'd3,          1'b1, 32'd0},
        '{ROW_PKT_KNOWN, 7'd0,   32'd30,         32'd3,          1'b0, 32'd30},
        '{ROW_CFG,       7'd0,   32'd0,          32'd0,          1'b0, 32'd0},
        '{ROW_PKT_KNOWN, 7'd0,   32'd40,         32'd1,          1'b1, 32'd0},
        '{ROW_PKT_KNOWN, 7'd0,   32'd50,         32'd0,          1'b1, 32'd0},
        '{ROW_CFG,       7'd127, 32'd0,          32'd0,          1'b0, 32'd0},
        '{ROW_PKT_KNOWN, 7'd0,   32'd60,         32'd7,          1'b0, 32'd60},
        '{ROW_PKT,       7'd0,   32'd59,         32'd1,          1'b0, 32'd0},
        '{ROW_PKT,       7'd0,   32'd67,         32'h0000_FFFF,  1'b0, 32'd0},
        '{ROW_CFG,       7'd64,  32'd0,          32'd0,          1'b0, 32'd0},
        '{ROW_PKT,       7'd0,   32'hFFFF_FFF0,  32'h0000_0020,  1'b0, 32'd0},
        '{ROW_PKT_KNOWN, 7'd0,   32'hFFFF_FFF0,  T_MAX,          1'b0, T_MAX},
        '{ROW_PKT_KNOWN, 7'd0,   T_MAX,          T_MAX,          1'b0, T_MAX},
        '{ROW_CFG,       7'd2,   32'd0,          32'd0,          1'b0, 32'd0},
        '{ROW_PKT_KNOWN, 7'd0,   32'hFFFF_FFFE,  32'd0,          1'b0, T_MAX},
        '{ROW_PKT_KNOWN, 7'd0,   32'hFFFF_FFFE,  32'd5,          1'b1, 32'd0},
        '{ROW_PKT_KNOWN, 7'd0,   T_MAX,          32'd0,          1'b0, T_MAX}
    };

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_ready;
    pbds_pkg::t_in_word          i_in_word   = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    pbds_pkg::t_out_word         o_out_word;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [pbds_pkg::SIZE_W-1:0] i_cfg_data  = '0;

    logic [pbds_pkg::TIME_W-1:0] finish_ticks [$];
    logic [pbds_pkg::TIME_W-1:0] last_finish_tick = '0;
    logic [pbds_pkg::SIZE_W-1:0] buffer_size_reg  = pbds_pkg::SIZE_W'(64);
    pbds_pkg::t_out_word         due_results [$];

    logic [pbds_pkg::TIME_W-1:0] tick_now    = '0;
    int unsigned       phase_span  = 1;
    int unsigned       phase_mul   = 1;
    int unsigned       gap_pct     = 0;
    int unsigned       stall_pct   = 0;
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;

    packet_buffer_drop_scheduler_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic pbds_pkg::t_out_word schedule_packet(input pbds_pkg::t_in_word w);
        pbds_pkg::t_out_word         r;
        int                          cap;
        logic [pbds_pkg::TIME_W:0]   sum;
        logic [pbds_pkg::TIME_W-1:0] begin_tick;
        cap = (int'(buffer_size_reg) > pbds_pkg::BUFFER_DEPTH) ? pbds_pkg::BUFFER_DEPTH
                                                               : int'(buffer_size_reg);
        while (finish_ticks.size() > 0 && finish_ticks[0] <= w.arr_tick)
            void'(finish_ticks.pop_front());
        if (finish_ticks.size() >= cap) begin
            r.dropped    = 1'b1;
            r.start_tick = '0;
            return r;
        end
        begin_tick = (w.arr_tick > last_finish_tick) ? w.arr_tick : last_finish_tick;
        sum = {1'b0, begin_tick} + {1'b0, w.proc_ticks};
        last_finish_tick = sum[pbds_pkg::TIME_W] ? T_MAX : sum[pbds_pkg::TIME_W-1:0];
        finish_ticks.insert(finish_ticks.size(), last_finish_tick);
        r.dropped    = 1'b0;
        r.start_tick = begin_tick;
        return r;
    endfunction

    // mostly overloaded traffic; sometimes land on the oldest finish tick, jump past
    // everything, or step backward
    function automatic pbds_pkg::t_in_word draw_packet();
        pbds_pkg::t_in_word w;
        int unsigned        pick;
        pick = $urandom_range(0, 199);
        if (pick == 0)
            tick_now = ((last_finish_tick > tick_now) ? last_finish_tick : tick_now)
                       + $urandom_range(0, phase_span);
        else if (pick < 20 && finish_ticks.size() > 0 && finish_ticks[0] > tick_now)
            tick_now = finish_ticks[0];
        else
            tick_now = tick_now + $urandom_range(0, phase_span);
        w.arr_tick = tick_now;
        if (pick >= 196 && tick_now >= phase_span)
            w.arr_tick = tick_now - $urandom_range(1, phase_span);
        w.proc_ticks = $urandom_range(0, phase_span * phase_mul);
        return w;
    endfunction

    task automatic send_packet(input pbds_pkg::t_in_word w, input logic known,
                               input pbds_pkg::t_out_word known_res);
        pbds_pkg::t_out_word predicted;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = schedule_packet(w);
        due_results.insert(due_results.size(), known ? known_res : predicted);
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_in_valid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_buffer_size(input logic [pbds_pkg::SIZE_W-1:0] v);
        drain_pipeline();
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        buffer_size_reg = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic apply_row(input t_script_row r);
        pbds_pkg::t_in_word  w;
        pbds_pkg::t_out_word res;
        w.arr_tick     = r.arrival;
        w.proc_ticks   = r.proc;
        res.dropped    = r.dropped;
        res.start_tick = r.start;
        if (r.kind == ROW_CFG)
            write_buffer_size(r.size);
        else
            send_packet(w, r.kind == ROW_PKT_KNOWN, res);
    endtask

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        pbds_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none, actual dropped=%0b start=%h",
                         $time, o_out_word.dropped, o_out_word.start_tick);
            end else begin
                want = due_results.pop_front();
                if (o_out_word.dropped !== want.dropped) begin
                    mismatch_count++;
                    $display("%0t: dropped expected %0b actual %0b",
                             $time, want.dropped, o_out_word.dropped);
                end
                if (o_out_word.start_tick !== want.start_tick) begin
                    mismatch_count++;
                    $display("%0t: start tick expected %h actual %h",
                             $time, want.start_tick, o_out_word.start_tick);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned p;
        int unsigned n;
        int unsigned items;
        int          i;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < OPENING_ROWS; i++)
            apply_row(stim_script[i]);

        tick_now = 100;
        for (p = 0; p < 8; p++) begin
            case (p)
                0, 5:    write_buffer_size(pbds_pkg::SIZE_W'(64));
                1:       write_buffer_size(pbds_pkg::SIZE_W'(127));
                2:       write_buffer_size(pbds_pkg::SIZE_W'(1));
                3:       write_buffer_size(pbds_pkg::SIZE_W'(0));
                4:       write_buffer_size(pbds_pkg::SIZE_W'($urandom_range(2, 8)));
                6:       write_buffer_size(pbds_pkg::SIZE_W'($urandom_range(9, 126)));
                default: write_buffer_size(pbds_pkg::SIZE_W'(3));
            endcase
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 79; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 79; end
                default: begin gap_pct = 9; stall_pct = 9; end
            endcase
            phase_span = 1 << $urandom_range(0, 10);
            phase_mul  = $urandom_range(1, 4);
            items      = (p == 3) ? 40 : 215;
            for (n = 0; n < items; n++) begin
                if (n == items / 2)
                    drain_pipeline();
                send_packet(draw_packet(), 1'b0, '0);
            end
        end

        gap_pct   = 0;
        stall_pct = 0;
        for (i = OPENING_ROWS; i < SCRIPT_ROWS; i++)
            apply_row(stim_script[i]);

        drain_pipeline();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
